@@ hdl/sgxs_pkg.sv @@
// Package for the Shell gap exchange sort core: beat types, data width and sequencer states.
// Has no dependencies. Every module of the block imports it.
`timescale 1ns / 1ps

package sgxs_pkg;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP,
		ST_RD_I,
		ST_LD_I,
		ST_RD_J,
		ST_CMP,
		ST_WB,
		ST_OUT_RD,
		ST_OUT
	} state_t;

endpackage

@@ hdl/shell_gap_exchange_sort_core.sv @@
// Shell sort core with halving gaps: loads a set of signed values, sorts them in place, emits them.
// Depends on sgxs_pkg. One element RAM (one write port, one registered read port), one comparator.
//
//  channel  | signals                  | handshake
//  ---------+--------------------------+---------------------------------------------
//  item     | item.value, item.last    | beat taken at clk edge with start & !busy
//  result   | result.sorted_value,     | beat shown for one cycle, result_strobe high,
//           | result.final_res         | receiver cannot stall
//
// Loading stores each beat taken while idle, up to DEPTH values. A beat with last set starts the
// sort: per gap s, each position i that has a partner is read into cur_q (ST_RD_I, ST_LD_I),
// compared and swapped against each partner j = i+s, i+2s, ... (ST_RD_J, ST_CMP) and written
// back (ST_WB), all through the single RAM port pair and comparator. Each result is read from
// the RAM (ST_OUT_RD) and then shown (ST_OUT). busy stays high from the closing beat until the
// final result. Reset clears the sequencer and counters only; the RAM holds no reset value.
`timescale 1ns / 1ps

module shell_gap_exchange_sort_core #(
	parameter int DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sgxs_pkg::item_t  item,
	output logic             busy,
	output logic             result_strobe,
	output sgxs_pkg::result_t result
);
	import sgxs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic signed [DATA_W-1:0] mem_q [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] n_q, n_d;
	logic [CW-1:0] s_q, s_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW:0]   j_q, j_d;
	logic [AW-1:0] k_q, k_d;
	logic signed [DATA_W-1:0] cur_q, cur_d;

	logic                     we;
	logic [AW-1:0]            wa;
	logic signed [DATA_W-1:0] wd;
	logic [AW-1:0]            ra;

	logic [CW:0] i_next_sum;
	logic [CW:0] j_next_sum;
	logic [CW-1:0] count_inc;
	logic accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign count_inc = count_q + CW'(1);
	assign i_next_sum = {1'b0, i_q} + {1'b0, s_q} + (CW+1)'(1);
	assign j_next_sum = j_q + {1'b0, s_q};

	// element RAM
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_data_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			n_q     <= '0;
			s_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			n_q     <= n_d;
			s_q     <= s_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		n_d     = n_q;
		s_d     = s_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		cur_d   = cur_q;
		we      = 1'b0;
		wa      = i_q[AW-1:0];
		wd      = cur_q;
		ra      = i_q[AW-1:0];
		result_strobe       = 1'b0;
		result.sorted_value = rd_data_q;
		result.final_res    = ({1'b0, k_q} + CW'(1)) == n_q;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// full store drops the value
					if (count_q < DEPTH_C) begin
						we      = 1'b1;
						wa      = count_q[AW-1:0];
						wd      = item.value;
						count_d = count_inc;
					end
					if (item.last) begin
						n_d     = (count_q < DEPTH_C) ? count_inc : count_q;
						s_d     = ((count_q < DEPTH_C) ? count_inc : count_q) >> 1;
						state_d = ST_GAP;
					end
				end
			end
			ST_GAP: begin
				i_d = '0;
				k_d = '0;
				state_d = (s_q == '0) ? ST_OUT_RD : ST_RD_I;
			end
			ST_RD_I: begin
				ra = i_q[AW-1:0];
				state_d = ST_LD_I;
			end
			ST_LD_I: begin
				cur_d = rd_data_q;
				j_d = {1'b0, i_q} + {1'b0, s_q};
				state_d = ST_RD_J;
			end
			ST_RD_J: begin
				ra = j_q[AW-1:0];
				state_d = ST_CMP;
			end
			ST_CMP: begin
				// running value at i is held in cur_q until write-back
				if (cur_q > rd_data_q) begin
					we    = 1'b1;
					wa    = j_q[AW-1:0];
					wd    = cur_q;
					cur_d = rd_data_q;
				end
				j_d = j_next_sum;
				state_d = (j_next_sum >= {1'b0, n_q}) ? ST_WB : ST_RD_J;
			end
			ST_WB: begin
				we = 1'b1;
				wa = i_q[AW-1:0];
				wd = cur_q;
				i_d = i_q + CW'(1);
				// positions with no partner inside the set do nothing
				if (i_next_sum >= {1'b0, n_q}) begin
					s_d = s_q >> 1;
					state_d = ST_GAP;
				end else begin
					state_d = ST_RD_I;
				end
			end
			ST_OUT_RD: begin
				ra = k_q;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				result_strobe = 1'b1;
				k_d = k_q + AW'(1);
				if (result.final_res) begin
					count_d = '0;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_OUT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result beat outside a busy window");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.final_res) |=> (!busy && count_q == '0))
		else $error("block not idle after final result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("element count beyond depth");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last) |=> (busy && n_q != '0))
		else $error("closing beat did not start a sort");

endmodule

@@ verif/shell_gap_exchange_sort_checker.sv @@
// Checker for the Shell gap exchange sort core: watches the item and result channels,
// keeps its own copy of the element store, predicts each sorted set and compares beats.
// Depends on sgxs_pkg.
`timescale 1ns / 1ps

module shell_gap_exchange_sort_checker #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  sgxs_pkg::item_t   item,
	input  logic              result_strobe,
	input  sgxs_pkg::result_t result,
	output int                fail_count,
	output int                pending
);
	import sgxs_pkg::*;

	logic signed [DATA_W-1:0] held_values [DEPTH];
	int held_count;
	result_t sorted_q [$];
	result_t want;

	function automatic void note_fault(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	// Sort the held set with halving gaps and queue it as the expected result beats.
	function automatic void sort_held_set();
		int n;
		int gap;
		int i;
		int j;
		logic signed [DATA_W-1:0] tmp;
		result_t r;
		n = held_count;
		for (gap = n / 2; gap > 0; gap = gap / 2) begin
			for (i = 0; i < n; i++) begin
				for (j = i + gap; j < n; j += gap) begin
					if (held_values[i] > held_values[j]) begin
						tmp = held_values[j];
						held_values[j] = held_values[i];
						held_values[i] = tmp;
					end
				end
			end
		end
		for (i = 0; i < n; i++) begin
			r.sorted_value = held_values[i];
			r.final_res = (i == n - 1);
			sorted_q.push_back(r);
		end
		held_count = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_q.delete();
			held_count = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_strobe) begin
				if (sorted_q.size() == 0) begin
					note_fault($sformatf("unexpected result beat: value %0d final %0b",
						result.sorted_value, result.final_res));
				end else begin
					want = sorted_q.pop_front();
					if (result.sorted_value !== want.sorted_value ||
							result.final_res !== want.final_res) begin
						note_fault($sformatf(
							"mismatch: expected value %0d final %0b, got value %0d final %0b",
							want.sorted_value, want.final_res,
							result.sorted_value, result.final_res));
					end
				end
			end
			if (start && !busy) begin
				// values past a full store are dropped, but last still closes the set
				if (held_count < DEPTH) begin
					held_values[held_count] = item.value;
					held_count++;
				end
				if (item.last) begin
					sort_held_set();
				end
			end
			pending = sorted_q.size();
		end
	end

endmodule

@@ verif/shell_gap_exchange_sort_core_test.sv @@
// Testbench top for the Shell gap exchange sort core: drives sets of signed values,
// directed then random, and reports the verdict. Depends on sgxs_pkg, the core and
// shell_gap_exchange_sort_checker.
`timescale 1ns / 1ps

module shell_gap_exchange_sort_core_test;
	import sgxs_pkg::*;

	localparam int DEPTH = 64;
	localparam int RANDOM_BEATS = 310;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    result_strobe;
	result_t result;
	int      fail_count;
	int      pending;
	logic    no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	shell_gap_exchange_sort_core #(
		.DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result_strobe(result_strobe),
		.result       (result)
	);

	shell_gap_exchange_sort_checker #(
		.DEPTH(DEPTH)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_strobe(result_strobe),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic is_last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.value = v;
		item.last = is_last;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		int t;
		case ($urandom_range(0, 5))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3: begin
				// narrow range forces duplicates
				t = $urandom_range(0, 15);
				return t - 8;
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int beats;
		int set_idx;
		int len;
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		no_gaps = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single element, reversed pair, extremes with duplicates, sorted run
		send_beat(VAL_MAX, 1'b1);
		send_beat(VAL_MAX, 1'b0);
		send_beat(VAL_MIN, 1'b1);
		send_beat(0, 1'b0);
		send_beat(-1, 1'b0);
		send_beat(VAL_MIN, 1'b0);
		send_beat(0, 1'b0);
		send_beat(-1, 1'b0);
		send_beat(VAL_MAX, 1'b1);
		send_beat(1, 1'b0);
		send_beat(2, 1'b0);
		send_beat(3, 1'b1);
		wait_drained();

		beats = 0;
		set_idx = 0;
		while (beats < RANDOM_BEATS) begin
			r = $urandom_range(0, 19);
			if (set_idx == 0) begin
				len = DEPTH + 3;  // overflow: extra values dropped, last still closes
			end else if (set_idx == 1 || r == 1) begin
				len = DEPTH;
			end else if (r == 0) begin
				len = DEPTH + $urandom_range(1, 3);
			end else begin
				len = $urandom_range(1, 12);
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				send_beat(pick_value(), k == len - 1);
			end
			beats += len;
			set_idx++;
			if (set_idx == 3 || $urandom_range(0, 4) == 0) begin
				start = 1'b0;
				wait_drained();
			end
		end
		start = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/sgxs_pkg.sv
hdl/shell_gap_exchange_sort_core.sv
verif/shell_gap_exchange_sort_checker.sv
verif/shell_gap_exchange_sort_core_test.sv
